### rtl/wmch_pkg.sv
// ----------------------------------------------------------------------------
// wmch_pkg
// Shared widths, codes and control types of the windowed multichannel
// histogram.
// ----------------------------------------------------------------------------
package wmch_pkg;

  // item field widths
  localparam int ActionWidth   = 2;
  localparam int ModuleWidth   = 1;
  localparam int ChannelWidth  = 4;
  localparam int SampleWidth   = 14;
  localparam int BinCountWidth = 32;

  // configuration port
  localparam int LimitWidth    = 14;
  localparam int CfgIndexWidth = 1;

  localparam logic [CfgIndexWidth-1:0] CfgLowerLimit = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CfgUpperLimit = 1'b1;

  localparam logic [LimitWidth-1:0] LowerLimitReset = 14'd100;
  localparam logic [LimitWidth-1:0] UpperLimitReset = 14'd7600;

  // default geometry of the store
  localparam int ModuleCountDefault  = 1;
  localparam int ChannelCountDefault = 16;
  localparam int BinCountDefault     = 8192;
  localparam int CountWidthDefault   = 32;

  // action codes
  localparam logic [ActionWidth-1:0] ActRecord = 2'd0;
  localparam logic [ActionWidth-1:0] ActRead   = 2'd1;
  localparam logic [ActionWidth-1:0] ActClear  = 2'd2;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic emit;
    logic clear_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_clear;
    logic clear_last;
    logic out_free;
  } ctrl_status_t;

endpackage

### rtl/wmch_in_if.sv
// ----------------------------------------------------------------------------
// wmch_in_if
// Input channel of the histogram: valid, ready and one item.
// ----------------------------------------------------------------------------
interface wmch_in_if;
  import wmch_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ActionWidth-1:0]  action;
  logic [ModuleWidth-1:0]  module_index;
  logic [ChannelWidth-1:0] channel_index;
  logic [SampleWidth-1:0]  sample_value;

  modport source (
    output valid, action, module_index, channel_index, sample_value,
    input  ready
  );

  modport sink (
    input  valid, action, module_index, channel_index, sample_value,
    output ready
  );

endinterface

### rtl/wmch_out_if.sv
// ----------------------------------------------------------------------------
// wmch_out_if
// Result channel of the histogram: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface wmch_out_if;
  import wmch_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BinCountWidth-1:0] bin_count;
  logic                     was_counted;

  modport source (
    output valid, bin_count, was_counted,
    input  ready
  );

  modport sink (
    input  valid, bin_count, was_counted,
    output ready
  );

endinterface

### rtl/wmch_ram.sv
// ----------------------------------------------------------------------------
// wmch_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wmch_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wmch_ctrl.sv
// ----------------------------------------------------------------------------
// wmch_ctrl
// Sequencer of the histogram: clearing sweep, item accept, bin lookup and
// result emit.
// ----------------------------------------------------------------------------
module wmch_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  wmch_pkg::ctrl_status_t status_i,
  output wmch_pkg::ctrl_cmd_t    cmd_o
);
  import wmch_pkg::*;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLookup,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   clear_item_q, clear_item_d;

  always_comb begin
    state_d      = state_q;
    clear_item_d = clear_item_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          // a clear item still owes its result, the reset sweep does not
          state_d = clear_item_q ? StEmit : StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.item_clear) begin
            state_d      = StClear;
            clear_item_d = 1'b1;
          end else begin
            state_d = StLookup;
          end
        end
      end
      StLookup: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit   = 1'b1;
          clear_item_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clear_item_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clear_item_q <= clear_item_d;
    end
  end

endmodule

### rtl/wmch_datapath.sv
// ----------------------------------------------------------------------------
// wmch_datapath
// Limit registers, item registers, bin address, saturating update, clearing
// cursor, bin store and result register.
// ----------------------------------------------------------------------------
module wmch_datapath #(
  parameter int ModuleCount  = wmch_pkg::ModuleCountDefault,
  parameter int ChannelCount = wmch_pkg::ChannelCountDefault,
  parameter int BinCount     = wmch_pkg::BinCountDefault,
  parameter int CountWidth   = wmch_pkg::CountWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [wmch_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [wmch_pkg::LimitWidth-1:0]    cfg_data_i,
  // input item
  input  logic [wmch_pkg::ActionWidth-1:0]   in_action_i,
  input  logic [wmch_pkg::ModuleWidth-1:0]   in_module_i,
  input  logic [wmch_pkg::ChannelWidth-1:0]  in_channel_i,
  input  logic [wmch_pkg::SampleWidth-1:0]   in_sample_i,
  // result item
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [wmch_pkg::BinCountWidth-1:0] out_bin_count_o,
  output logic                               out_was_counted_o,
  // controller
  input  wmch_pkg::ctrl_cmd_t                cmd_i,
  output wmch_pkg::ctrl_status_t             status_o
);
  import wmch_pkg::*;

  localparam int StoreDepth = ModuleCount * ChannelCount * BinCount;
  localparam int AddrWidth  = $clog2(StoreDepth);
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(StoreDepth - 1);

  logic [LimitWidth-1:0]  lower_q, upper_q;
  logic [ActionWidth-1:0] action_q;
  logic [SampleWidth-1:0] value_q;
  logic [AddrWidth-1:0]   addr_q, addr_d;
  logic                   in_range_q, in_range_d;
  logic [AddrWidth-1:0]   cursor_q;
  logic                   out_valid_q;
  logic [BinCountWidth-1:0] bin_count_q, bin_count_d;
  logic                   was_counted_q, was_counted_d;

  logic [31:0]            flat_addr;
  logic [CountWidth-1:0]  rdata, count_sat, count_res;
  logic [63:0]            count_ext;
  logic                   in_window;
  logic                   ram_we;
  logic [AddrWidth-1:0]   ram_waddr;
  logic [CountWidth-1:0]  ram_wdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LowerLimitReset;
      upper_q <= UpperLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLowerLimit: lower_q <= cfg_data_i;
        CfgUpperLimit: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flat bin address: module, then channel, then bin
  assign flat_addr = (32'(in_module_i) * 32'(ChannelCount) + 32'(in_channel_i))
                     * 32'(BinCount) + 32'(in_sample_i);
  assign addr_d     = flat_addr[AddrWidth-1:0];
  assign in_range_d = (32'(in_module_i) < 32'(ModuleCount))
                   && (32'(in_channel_i) < 32'(ChannelCount))
                   && (32'(in_sample_i) < 32'(BinCount));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q   <= in_action_i;
      value_q    <= in_sample_i;
      addr_q     <= addr_d;
      in_range_q <= in_range_d;
    end
  end

  // clearing cursor, back at zero once a sweep ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (cmd_i.clear_step) begin
      cursor_q <= (cursor_q == LastAddr) ? '0 : cursor_q + 1'b1;
    end
  end

  assign in_window = (value_q > lower_q) && (value_q < upper_q);
  assign count_sat = (rdata == {CountWidth{1'b1}}) ? rdata : rdata + 1'b1;

  always_comb begin
    count_res     = '0;
    was_counted_d = 1'b0;
    case (action_q)
      ActRecord: begin
        if (in_range_q) begin
          was_counted_d = in_window;
          count_res     = in_window ? count_sat : rdata;
        end
      end
      ActRead: begin
        if (in_range_q) begin
          count_res = rdata;
        end
      end
      default: ;
    endcase
  end

  assign count_ext   = 64'(count_res);
  assign bin_count_d = count_ext[BinCountWidth-1:0];

  assign ram_we    = cmd_i.clear_step
                  || (cmd_i.emit && (action_q == ActRecord) && in_range_q && in_window);
  assign ram_waddr = cmd_i.clear_step ? cursor_q : addr_q;
  assign ram_wdata = cmd_i.clear_step ? '0 : count_sat;

  wmch_ram #(
    .Width (CountWidth),
    .Depth (StoreDepth)
  ) u_bin_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      bin_count_q   <= bin_count_d;
      was_counted_q <= was_counted_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_bin_count_o   = bin_count_q;
  assign out_was_counted_o = was_counted_q;

  assign status_o.item_clear = (in_action_i == ActClear);
  assign status_o.clear_last = (cursor_q == LastAddr);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### rtl/windowed_multichannel_histogram_top.sv
// ----------------------------------------------------------------------------
// windowed_multichannel_histogram_top
// Per-channel pulse-height histogram with a lower and upper counting window.
// ----------------------------------------------------------------------------
// A record item adds one to the bin of its ADC value in its channel's spectrum
// when the value lies strictly inside the window, saturating at all ones; a
// read item returns one bin; a clear item zeroes the store. Every item gives
// one result item. Record and read items pass through accept, read of the bin
// store's registered read port, then update and result load, which waits for
// a free result register; the next item is taken only after that, and the
// result register lets it in while a result waits. A clear item, and the
// clearing pass after reset, sweep the store one bin a cycle through the RAM
// write port, with no item taken meanwhile; the user is to make configuration
// writes only while the block is idle; the block does not enforce this.
module windowed_multichannel_histogram_top #(
  parameter int ModuleCount  = wmch_pkg::ModuleCountDefault,
  parameter int ChannelCount = wmch_pkg::ChannelCountDefault,
  parameter int BinCount     = wmch_pkg::BinCountDefault,
  parameter int CountWidth   = wmch_pkg::CountWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wmch_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [wmch_pkg::LimitWidth-1:0]    cfg_data_i,
  wmch_in_if.sink                            in_i,
  wmch_out_if.source                         out_o
);
  import wmch_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  wmch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmch_datapath #(
    .ModuleCount  (ModuleCount),
    .ChannelCount (ChannelCount),
    .BinCount     (BinCount),
    .CountWidth   (CountWidth)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_action_i       (in_i.action),
    .in_module_i       (in_i.module_index),
    .in_channel_i      (in_i.channel_index),
    .in_sample_i       (in_i.sample_value),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_bin_count_o   (out_o.bin_count),
    .out_was_counted_o (out_o.was_counted),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule
